@@ sv/pidacc_pkg.sv @@
package pidacc_pkg;

    // field widths
    localparam int AXIS_W  = 2;
    localparam int DATA_W  = 32;
    localparam int GAIN_W  = 16;
    localparam int LIM_W   = 31;
    localparam int CIDX_W  = 4;
    localparam int FRAC_W  = 12;

    // internal widths
    localparam int ERR_W   = DATA_W + 1;            // exact difference of two Q16.16 values
    localparam int SUMI_W  = DATA_W + 2;            // integrator plus error
    localparam int PROD_W  = GAIN_W + 1 + ERR_W;    // unsigned gain times signed error
    localparam int IPROD_W = GAIN_W + 1 + DATA_W;   // unsigned gain times signed integrator
    localparam int ACC_W   = 40;                    // wide accumulation of the terms

    // integrator store
    localparam int NUM_AXES = 3;

    // axis codes
    typedef enum logic [AXIS_W-1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    // register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_KP_XY        = 4'd0,
        REG_KD_XY        = 4'd1,
        REG_KI_XY        = 4'd2,
        REG_KP_Z         = 4'd3,
        REG_KD_Z         = 4'd4,
        REG_KI_Z         = 4'd5,
        REG_INTEG_LIMIT  = 4'd6,
        REG_ACC_XY_LIMIT = 4'd7
    } cfg_reg_t;

    // register reset values
    localparam logic [GAIN_W-1:0] KP_XY_RST        = 16'd4096;
    localparam logic [GAIN_W-1:0] KD_XY_RST        = 16'd8192;
    localparam logic [GAIN_W-1:0] KI_XY_RST        = 16'd82;
    localparam logic [GAIN_W-1:0] KP_Z_RST         = 16'd6922;
    localparam logic [GAIN_W-1:0] KD_Z_RST         = 16'd11715;
    localparam logic [GAIN_W-1:0] KI_Z_RST         = 16'd819;
    localparam logic [LIM_W-1:0]  INTEG_LIMIT_RST  = 31'd983040;
    localparam logic [LIM_W-1:0]  ACC_XY_LIMIT_RST = 31'd327680;

    // gravity and z window, Q16.16
    localparam logic signed [ACC_W-1:0] GRAV_Q16 = 40'sd642908;
    localparam logic signed [ACC_W-1:0] ZMAX_Q16 = 40'sd1285816;
    localparam logic signed [ACC_W-1:0] ZMIN_Q16 = 40'sd192872;

endpackage

@@ sv/position_pid_accel_command_core.sv @@
// position pid controller with acceleration feedforward, one axis per item
//
// input channel: in_valid / in_stall with axis, ref_pos, ref_vel, ref_acc,
// meas_pos, meas_vel (Q16.16). an item is taken at a clock edge with
// in_valid high and in_stall low. an item with axis code three is taken
// and dropped: it changes nothing and gives no result.
// output channel: out_valid / out_stall with axis_out and target_acc.
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, indexes above seven are dropped.
//
// throughput: one item per cycle when the receiver does not stall. an item
// moves through the s1, s2, s3 and output registers (integrator update with
// p and d products, integral product, final sum and clamp into the output register).
// the rate is set by the read-modify-write of the three-entry integrator
// ram, with the entry written by the item just ahead forwarded to the next.
// when the receiver stalls, the output register holds and the stages
// behind it fill; in_stall rises once the first stage cannot move.
// reset (rst_n low, asynchronous) empties the pipeline, restores the gains
// and limits to their defaults and marks every integrator as zero.
module position_pid_accel_command_core (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pidacc_pkg::AXIS_W-1:0]        axis,
    input  logic signed [pidacc_pkg::DATA_W-1:0] ref_pos,
    input  logic signed [pidacc_pkg::DATA_W-1:0] ref_vel,
    input  logic signed [pidacc_pkg::DATA_W-1:0] ref_acc,
    input  logic signed [pidacc_pkg::DATA_W-1:0] meas_pos,
    input  logic signed [pidacc_pkg::DATA_W-1:0] meas_vel,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pidacc_pkg::AXIS_W-1:0]        axis_out,
    output logic signed [pidacc_pkg::DATA_W-1:0] target_acc,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pidacc_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [pidacc_pkg::DATA_W-1:0]        cfg_data
);

    localparam int AXIS_W  = pidacc_pkg::AXIS_W;
    localparam int DATA_W  = pidacc_pkg::DATA_W;
    localparam int GAIN_W  = pidacc_pkg::GAIN_W;
    localparam int LIM_W   = pidacc_pkg::LIM_W;
    localparam int FRAC_W  = pidacc_pkg::FRAC_W;
    localparam int ERR_W   = pidacc_pkg::ERR_W;
    localparam int SUMI_W  = pidacc_pkg::SUMI_W;
    localparam int PROD_W  = pidacc_pkg::PROD_W;
    localparam int IPROD_W = pidacc_pkg::IPROD_W;
    localparam int ACC_W   = pidacc_pkg::ACC_W;
    localparam int NAX     = pidacc_pkg::NUM_AXES;
    localparam int PSH_W   = PROD_W - FRAC_W;
    localparam int ISH_W   = IPROD_W - FRAC_W;

    // configuration registers
    logic [GAIN_W-1:0] kp_xy_reg, kd_xy_reg, ki_xy_reg;
    logic [GAIN_W-1:0] kp_z_reg, kd_z_reg, ki_z_reg;
    logic [LIM_W-1:0]  integ_limit_reg, acc_xy_limit_reg;

    // pipeline registers
    logic                     s1_valid_reg, s1_valid_next;
    logic [AXIS_W-1:0]        s1_axis_reg;
    logic signed [ERR_W-1:0]  s1_pos_err_reg, s1_vel_err_reg;
    logic signed [DATA_W-1:0] s1_ref_acc_reg;
    logic                     s1_fwd_reg, s1_fwd_next;
    logic signed [DATA_W-1:0] s1_fwd_val_reg;
    logic                     s1_hit_reg;

    logic                     s2_valid_reg;
    logic [AXIS_W-1:0]        s2_axis_reg;
    logic signed [DATA_W-1:0] s2_integ_reg;
    logic signed [PROD_W-1:0] s2_pprod_reg, s2_dprod_reg;
    logic signed [DATA_W-1:0] s2_ref_acc_reg;

    logic                      s3_valid_reg;
    logic [AXIS_W-1:0]         s3_axis_reg;
    logic signed [ACC_W-1:0]   s3_sum_reg;
    logic signed [IPROD_W-1:0] s3_iprod_reg;

    logic                     out_valid_reg;
    logic [AXIS_W-1:0]        out_axis_reg;
    logic signed [DATA_W-1:0] out_acc_reg;

    // integrator store valid bits, cleared at reset
    logic [NAX-1:0] integ_vld_reg, integ_vld_next;

    // handshake and flow control
    logic in_fire, cfg_fire;
    logic s1_open, s2_open, s3_open, out_open;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign out_open = !out_valid_reg || !out_stall;
    assign s3_open  = !s3_valid_reg || out_open;
    assign s2_open  = !s2_valid_reg || s3_open;
    assign s1_open  = !s1_valid_reg || s2_open;

    assign in_stall = !s1_open;
    assign in_fire  = in_valid && s1_open;

    // ram signals
    logic                     ram_we, ram_re;
    logic [AXIS_W-1:0]        ram_waddr, ram_raddr;
    logic signed [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0]        ram_rdata;

    // configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_xy_reg        <= pidacc_pkg::KP_XY_RST;
            kd_xy_reg        <= pidacc_pkg::KD_XY_RST;
            ki_xy_reg        <= pidacc_pkg::KI_XY_RST;
            kp_z_reg         <= pidacc_pkg::KP_Z_RST;
            kd_z_reg         <= pidacc_pkg::KD_Z_RST;
            ki_z_reg         <= pidacc_pkg::KI_Z_RST;
            integ_limit_reg  <= pidacc_pkg::INTEG_LIMIT_RST;
            acc_xy_limit_reg <= pidacc_pkg::ACC_XY_LIMIT_RST;
        end
        else if (cfg_fire)
        begin
            unique case (pidacc_pkg::cfg_reg_t'(cfg_index))
                pidacc_pkg::REG_KP_XY:        kp_xy_reg        <= cfg_data[GAIN_W-1:0];
                pidacc_pkg::REG_KD_XY:        kd_xy_reg        <= cfg_data[GAIN_W-1:0];
                pidacc_pkg::REG_KI_XY:        ki_xy_reg        <= cfg_data[GAIN_W-1:0];
                pidacc_pkg::REG_KP_Z:         kp_z_reg         <= cfg_data[GAIN_W-1:0];
                pidacc_pkg::REG_KD_Z:         kd_z_reg         <= cfg_data[GAIN_W-1:0];
                pidacc_pkg::REG_KI_Z:         ki_z_reg         <= cfg_data[GAIN_W-1:0];
                pidacc_pkg::REG_INTEG_LIMIT:  integ_limit_reg  <= cfg_data[LIM_W-1:0];
                pidacc_pkg::REG_ACC_XY_LIMIT: acc_xy_limit_reg <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 0: errors, integrator read and forward detect
    logic                     in_live;
    logic signed [ERR_W-1:0]  pos_err, vel_err;
    logic signed [DATA_W-1:0] integ_val;

    assign in_live   = (pidacc_pkg::axis_t'(axis) != pidacc_pkg::AXIS_NONE);
    assign pos_err   = ERR_W'(ref_pos) - ERR_W'(meas_pos);
    assign vel_err   = ERR_W'(ref_vel) - ERR_W'(meas_vel);
    assign ram_re    = in_fire && in_live;
    assign ram_raddr = axis;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_open)
        begin
            s1_valid_next = in_valid && in_live;
        end
        // the item now leaving stage 1 writes the entry this one reads
        s1_fwd_next = s1_valid_reg && (s1_axis_reg == axis);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_axis_reg    <= axis;
            s1_pos_err_reg <= pos_err;
            s1_vel_err_reg <= vel_err;
            s1_ref_acc_reg <= ref_acc;
            s1_fwd_reg     <= s1_fwd_next;
            s1_fwd_val_reg <= integ_val;
            s1_hit_reg     <= integ_vld_reg[axis];
        end
    end

    // stage 1: integrator update and clamp, p and d products
    logic signed [DATA_W-1:0] integ_old;
    logic signed [SUMI_W-1:0] integ_sum, integ_lim;
    logic [GAIN_W-1:0]        kp_sel, kd_sel;

    assign integ_lim = SUMI_W'(integ_limit_reg);

    always_comb
    begin
        priority if (s1_fwd_reg)
        begin
            integ_old = s1_fwd_val_reg;
        end
        else if (s1_hit_reg)
        begin
            integ_old = $signed(ram_rdata);
        end
        else
        begin
            integ_old = '0;
        end
        integ_sum = SUMI_W'(integ_old) + SUMI_W'(s1_pos_err_reg);
        priority if (integ_sum > integ_lim)
        begin
            integ_val = DATA_W'(integ_lim);
        end
        else if (integ_sum < -integ_lim)
        begin
            integ_val = DATA_W'(-integ_lim);
        end
        else
        begin
            integ_val = DATA_W'(integ_sum);
        end
    end

    assign ram_we    = s1_valid_reg && s2_open;
    assign ram_waddr = s1_axis_reg;
    assign ram_wdata = integ_val;

    always_comb
    begin
        integ_vld_next = integ_vld_reg;
        if (ram_we)
        begin
            integ_vld_next[s1_axis_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_vld_reg <= '0;
        end
        else
        begin
            integ_vld_reg <= integ_vld_next;
        end
    end

    assign kp_sel = (pidacc_pkg::axis_t'(s1_axis_reg) == pidacc_pkg::AXIS_Z) ? kp_z_reg
                                                                             : kp_xy_reg;
    assign kd_sel = (pidacc_pkg::axis_t'(s1_axis_reg) == pidacc_pkg::AXIS_Z) ? kd_z_reg
                                                                             : kd_xy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_open)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_open)
        begin
            s2_axis_reg    <= s1_axis_reg;
            s2_integ_reg   <= integ_val;
            s2_pprod_reg   <= $signed({1'b0, kp_sel}) * s1_pos_err_reg;
            s2_dprod_reg   <= $signed({1'b0, kd_sel}) * s1_vel_err_reg;
            s2_ref_acc_reg <= s1_ref_acc_reg;
        end
    end

    // stage 2: integral product, sum of p, d, feedforward and gravity
    logic [GAIN_W-1:0]        ki_sel;
    logic signed [PSH_W-1:0]  p_term, d_term;
    logic signed [ACC_W-1:0]  grav_term, sum_pd;
    logic                     s2_is_z;

    assign s2_is_z   = (pidacc_pkg::axis_t'(s2_axis_reg) == pidacc_pkg::AXIS_Z);
    assign ki_sel    = s2_is_z ? ki_z_reg : ki_xy_reg;
    assign p_term    = s2_pprod_reg[PROD_W-1:FRAC_W];
    assign d_term    = s2_dprod_reg[PROD_W-1:FRAC_W];
    assign grav_term = s2_is_z ? pidacc_pkg::GRAV_Q16 : '0;
    assign sum_pd    = ACC_W'(p_term) + ACC_W'(d_term) + ACC_W'(s2_ref_acc_reg) + grav_term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_open)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_open)
        begin
            s3_axis_reg  <= s2_axis_reg;
            s3_sum_reg   <= sum_pd;
            s3_iprod_reg <= $signed({1'b0, ki_sel}) * s2_integ_reg;
        end
    end

    // stage 3: final sum and output clamp
    logic signed [ISH_W-1:0] i_term;
    logic signed [ACC_W-1:0] acc_full, acc_lo, acc_hi, acc_clamped;

    assign i_term   = s3_iprod_reg[IPROD_W-1:FRAC_W];
    assign acc_full = s3_sum_reg + ACC_W'(i_term);

    always_comb
    begin
        if (pidacc_pkg::axis_t'(s3_axis_reg) == pidacc_pkg::AXIS_Z)
        begin
            acc_lo = pidacc_pkg::ZMIN_Q16;
            acc_hi = pidacc_pkg::ZMAX_Q16;
        end
        else
        begin
            acc_hi = ACC_W'(acc_xy_limit_reg);
            acc_lo = -acc_hi;
        end
        priority if (acc_full > acc_hi)
        begin
            acc_clamped = acc_hi;
        end
        else if (acc_full < acc_lo)
        begin
            acc_clamped = acc_lo;
        end
        else
        begin
            acc_clamped = acc_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_open)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_open)
        begin
            out_axis_reg <= s3_axis_reg;
            out_acc_reg  <= DATA_W'(acc_clamped);
        end
    end

    assign out_valid  = out_valid_reg;
    assign axis_out   = out_axis_reg;
    assign target_acc = out_acc_reg;

    // integrator store
    pidacc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NAX)
    ) u_integ_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // checks
    a_no_none_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (axis_out != pidacc_pkg::AXIS_NONE))
        else $error("result carries axis code three");

    a_z_window: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && axis_out == pidacc_pkg::AXIS_Z) |->
            (ACC_W'(target_acc) >= pidacc_pkg::ZMIN_Q16 &&
             ACC_W'(target_acc) <= pidacc_pkg::ZMAX_Q16))
        else $error("z acceleration outside its window");

    a_xy_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && axis_out != pidacc_pkg::AXIS_Z) |->
            (ACC_W'(target_acc) <= $signed(ACC_W'(acc_xy_limit_reg)) &&
             ACC_W'(target_acc) >= -$signed(ACC_W'(acc_xy_limit_reg))))
        else $error("x/y acceleration beyond its limit");

    a_integ_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (SUMI_W'(ram_wdata) <= integ_lim && SUMI_W'(ram_wdata) >= -integ_lim))
        else $error("integrator written beyond its limit");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg))
        else $error("input stalled with an empty stage");

endmodule

@@ sv/pidacc_ram.sv @@
module pidacc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ tb/sv/accel_command_checker.sv @@
`timescale 1ns / 1ps

module accel_command_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [pidacc_pkg::AXIS_W-1:0]        axis,
    input  logic signed [pidacc_pkg::DATA_W-1:0] ref_pos,
    input  logic signed [pidacc_pkg::DATA_W-1:0] ref_vel,
    input  logic signed [pidacc_pkg::DATA_W-1:0] ref_acc,
    input  logic signed [pidacc_pkg::DATA_W-1:0] meas_pos,
    input  logic signed [pidacc_pkg::DATA_W-1:0] meas_vel,

    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic [pidacc_pkg::AXIS_W-1:0]        axis_out,
    input  logic signed [pidacc_pkg::DATA_W-1:0] target_acc,

    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [pidacc_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [pidacc_pkg::DATA_W-1:0]        cfg_data,

    output int                                   fail_count,
    output int                                   pending,
    output int                                   checked
);

    import pidacc_pkg::*;

    typedef struct {
        axis_t                    ax;
        logic signed [DATA_W-1:0] acc;
    } accel_cmd_t;

    // gains, limits and integrators as the block should hold them
    logic [GAIN_W-1:0] kp_xy_g, kd_xy_g, ki_xy_g, kp_z_g, kd_z_g, ki_z_g;
    logic [LIM_W-1:0]  integ_lim, acc_lim;
    longint            integ_st [NUM_AXES];

    // commands still owed by the block, oldest first
    accel_cmd_t        accel_due [$];

    function automatic longint clamp_q(longint v, longint lo, longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // one axis update: integrator, pid sum with feedforward, output clamp
    function automatic logic signed [DATA_W-1:0] predict_accel(
        axis_t ax, logic signed [DATA_W-1:0] rp, logic signed [DATA_W-1:0] rv,
        logic signed [DATA_W-1:0] ra, logic signed [DATA_W-1:0] mp,
        logic signed [DATA_W-1:0] mv);
        longint perr, verr, lim, integ, acc, kp, kd, ki;
        perr = longint'(rp) - longint'(mp);
        verr = longint'(rv) - longint'(mv);
        lim = longint'(integ_lim);
        integ = clamp_q(integ_st[ax] + perr, -lim, lim);
        integ_st[ax] = integ;
        if (ax == AXIS_Z) begin
            kp = longint'(kp_z_g);
            kd = longint'(kd_z_g);
            ki = longint'(ki_z_g);
        end
        else begin
            kp = longint'(kp_xy_g);
            kd = longint'(kd_xy_g);
            ki = longint'(ki_xy_g);
        end
        // products floor toward minus infinity
        acc = ((kp * perr) >>> FRAC_W) + ((kd * verr) >>> FRAC_W)
            + longint'(ra) + ((ki * integ) >>> FRAC_W);
        if (ax == AXIS_Z)
            acc = clamp_q(acc + longint'(GRAV_Q16), longint'(ZMIN_Q16), longint'(ZMAX_Q16));
        else
            acc = clamp_q(acc, -longint'(acc_lim), longint'(acc_lim));
        return acc[DATA_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n) begin
        accel_cmd_t want;
        if (!rst_n) begin
            kp_xy_g = KP_XY_RST;
            kd_xy_g = KD_XY_RST;
            ki_xy_g = KI_XY_RST;
            kp_z_g = KP_Z_RST;
            kd_z_g = KD_Z_RST;
            ki_z_g = KI_Z_RST;
            integ_lim = INTEG_LIMIT_RST;
            acc_lim = ACC_XY_LIMIT_RST;
            for (int i = 0; i < NUM_AXES; i++)
                integ_st[i] = 0;
            accel_due.delete();
            fail_count = 0;
            checked = 0;
            pending <= 0;
        end
        else begin
            // results leaving the block
            if (out_valid && !out_stall) begin
                if (accel_due.size() == 0) begin
                    $error("unexpected result: axis_out %0d target_acc %0d",
                           axis_out, target_acc);
                    fail_count++;
                end
                else begin
                    want = accel_due.pop_front();
                    checked++;
                    if (axis_out !== want.ax) begin
                        $error("axis_out mismatch: expected %0d, actual %0d",
                               want.ax, axis_out);
                        fail_count++;
                    end
                    if (target_acc !== want.acc) begin
                        $error("target_acc mismatch: expected %0d, actual %0d",
                               want.acc, target_acc);
                        fail_count++;
                    end
                end
            end

            // register writes, unknown indexes are dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KP_XY:        kp_xy_g = cfg_data[GAIN_W-1:0];
                    REG_KD_XY:        kd_xy_g = cfg_data[GAIN_W-1:0];
                    REG_KI_XY:        ki_xy_g = cfg_data[GAIN_W-1:0];
                    REG_KP_Z:         kp_z_g = cfg_data[GAIN_W-1:0];
                    REG_KD_Z:         kd_z_g = cfg_data[GAIN_W-1:0];
                    REG_KI_Z:         ki_z_g = cfg_data[GAIN_W-1:0];
                    REG_INTEG_LIMIT:  integ_lim = cfg_data[LIM_W-1:0];
                    REG_ACC_XY_LIMIT: acc_lim = cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end

            // accepted items, axis three leaves no trace
            if (in_valid && !in_stall && axis_t'(axis) != AXIS_NONE) begin
                want.ax = axis_t'(axis);
                want.acc = predict_accel(want.ax, ref_pos, ref_vel, ref_acc,
                                         meas_pos, meas_vel);
                accel_due.push_back(want);
            end

            pending <= accel_due.size();
        end
    end

endmodule

@@ tb/sv/position_pid_accel_command_core_test.sv @@
`timescale 1ns / 1ps

module position_pid_accel_command_core_test;

    import pidacc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 12;
    localparam logic signed [DATA_W-1:0] DMAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] DMIN = 32'sh8000_0000;
    localparam int SPAN = 1 << 18;
    localparam int NEAR = 1 << 16;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [AXIS_W-1:0]        axis;
    logic signed [DATA_W-1:0] ref_pos, ref_vel, ref_acc, meas_pos, meas_vel;
    logic                     out_valid;
    logic                     out_stall;
    logic [AXIS_W-1:0]        axis_out;
    logic signed [DATA_W-1:0] target_acc;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CIDX_W-1:0]        cfg_index;
    logic [DATA_W-1:0]        cfg_data;

    int fail_count, pending, checked;
    int cycle_count = 0;
    int items_sent = 0;
    int items_dropped = 0;
    int reg_writes = 0;
    bit quiet = 1'b0;

    always #6 clk = ~clk;

    position_pid_accel_command_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .axis(axis),
        .ref_pos(ref_pos), .ref_vel(ref_vel), .ref_acc(ref_acc),
        .meas_pos(meas_pos), .meas_vel(meas_vel),
        .out_valid(out_valid), .out_stall(out_stall),
        .axis_out(axis_out), .target_acc(target_acc),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    accel_command_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .axis(axis),
        .ref_pos(ref_pos), .ref_vel(ref_vel), .ref_acc(ref_acc),
        .meas_pos(meas_pos), .meas_vel(meas_vel),
        .out_valid(out_valid), .out_stall(out_stall),
        .axis_out(axis_out), .target_acc(target_acc),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // sender gap: mostly none, a few long
    function automatic int sender_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver stall pattern
    initial
    begin
        int r;
        out_stall <= 1'b0;
        forever
        begin
            r = $urandom_range(99);
            if (r < 70)
                repeat ($urandom_range(1, 8)) @(posedge clk);
            else if (r < 90)
                repeat ($urandom_range(9, 30)) @(posedge clk);
            else
                repeat ($urandom_range(40, 120)) @(posedge clk);
            if (!quiet)
            begin
                out_stall <= 1'b1;
                r = $urandom_range(99);
                if (r < 75)
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                else if (r < 93)
                    repeat ($urandom_range(4, 10)) @(posedge clk);
                else
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // one item, held until taken
    task automatic send_item(input axis_t ax, input logic signed [DATA_W-1:0] rp,
                             input logic signed [DATA_W-1:0] rv,
                             input logic signed [DATA_W-1:0] ra,
                             input logic signed [DATA_W-1:0] mp,
                             input logic signed [DATA_W-1:0] mv);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        axis <= ax;
        ref_pos <= rp;
        ref_vel <= rv;
        ref_acc <= ra;
        meas_pos <= mp;
        meas_vel <= mv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (ax == AXIS_NONE)
            items_dropped++;
    endtask

    // field value: extremes, full range or near the origin
    function automatic logic signed [DATA_W-1:0] pick_q16();
        int r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            case ($urandom_range(4))
                0: return DMAX;
                1: return DMIN;
                2: return 0;
                3: return -1;
                default: return 1;
            endcase
        end
        if (r < 40)
            return $urandom;
        return int'($urandom_range(0, 2 * SPAN)) - SPAN;
    endfunction

    // measured value: mostly close to the reference
    function automatic logic signed [DATA_W-1:0] near(logic signed [DATA_W-1:0] v);
        if ($urandom_range(99) < 70)
            return v + (int'($urandom_range(0, 2 * NEAR)) - NEAR);
        return pick_q16();
    endfunction

    task automatic run_random(input int n, input bit drive_up);
        axis_t ax;
        logic signed [DATA_W-1:0] rp, rv, ra, mp, mv;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 6)
                ax = AXIS_NONE;
            else
                ax = axis_t'($urandom_range(0, 2));
            rp = pick_q16();
            rv = pick_q16();
            ra = pick_q16();
            mp = near(rp);
            mv = near(rv);
            // large positive errors to wind the integrators up
            if (drive_up)
            begin
                rp = $urandom_range(0, 1 << 30);
                mp = -int'($urandom_range(0, 1 << 30));
            end
            send_item(ax, rp, rv, ra, mp, mv);
        end
    endtask

    // wait until every command is back and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    task automatic load_all(input logic [DATA_W-1:0] kpxy, input logic [DATA_W-1:0] kdxy,
                            input logic [DATA_W-1:0] kixy, input logic [DATA_W-1:0] kpz,
                            input logic [DATA_W-1:0] kdz, input logic [DATA_W-1:0] kiz,
                            input logic [DATA_W-1:0] ilim, input logic [DATA_W-1:0] alim);
        write_reg(REG_KP_XY, kpxy);
        write_reg(REG_KD_XY, kdxy);
        write_reg(REG_KI_XY, kixy);
        write_reg(REG_KP_Z, kpz);
        write_reg(REG_KD_Z, kdz);
        write_reg(REG_KI_Z, kiz);
        write_reg(REG_INTEG_LIMIT, ilim);
        write_reg(REG_ACC_XY_LIMIT, alim);
    endtask

    function automatic logic [DATA_W-1:0] rand_limit();
        if ($urandom_range(1))
            return $urandom;
        return $urandom_range(0, 1 << 20);
    endfunction

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        axis <= AXIS_X;
        ref_pos <= '0;
        ref_vel <= '0;
        ref_acc <= '0;
        meas_pos <= '0;
        meas_vel <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_KP_XY;
        cfg_data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at reset gains
        send_item(AXIS_X, 0, 0, 0, 0, 0);
        send_item(AXIS_Y, 0, 0, 0, 0, 0);
        send_item(AXIS_Z, 0, 0, 0, 0, 0);
        send_item(AXIS_X, 1, 0, 0, 2, 0);
        send_item(AXIS_Y, 0, -1, -1, 0, 0);
        send_item(AXIS_X, DMAX, DMAX, DMAX, DMIN, DMIN);
        send_item(AXIS_Y, DMIN, DMIN, DMIN, DMAX, DMAX);
        send_item(AXIS_Z, DMAX, DMAX, DMAX, DMIN, DMIN);
        send_item(AXIS_Z, DMIN, DMIN, DMIN, DMAX, DMAX);
        send_item(AXIS_NONE, DMAX, DMAX, DMAX, DMIN, DMIN);
        send_item(AXIS_X, 32'sh0001_0000, 0, 0, 0, 0);
        send_item(AXIS_NONE, 0, 0, 0, 0, 0);
        send_item(AXIS_Z, 0, 0, -32'sd450000, 0, 0);
        send_item(AXIS_Y, -1, -1, -1, -1, -1);
        send_item(AXIS_X, 0, DMIN, 0, 0, DMAX);
        send_item(AXIS_Z, 32'sh0000_8000, 32'sh0002_0000, 32'sh0001_0000, 0, 0);
        send_item(AXIS_Y, -32'sh0001_0000, 32'sh0000_4000, 32'sh0003_0000, 0, 0);
        send_item(AXIS_Z, DMIN, 0, DMAX, DMIN, 0);
        run_random(80, 1'b0);
        settle();

        // top gains and widest limits, back to back
        quiet = 1'b1;
        load_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        run_random(60, 1'b0);
        settle();
        quiet = 1'b0;

        // every gain and limit at zero
        load_all(0, 0, 0, 0, 0, 0, 0, 0);
        run_random(50, 1'b0);
        settle();

        // random settings, after stray index writes that must change nothing
        for (int k = 1; k <= 8; k++)
            write_reg(CIDX_W'(REG_ACC_XY_LIMIT) + CIDX_W'(k), $urandom);
        load_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 rand_limit(), rand_limit());
        run_random(70, 1'b0);
        settle();

        // wind the integrators up, then pull the limit in under them
        load_all($urandom_range(0, 8192), $urandom_range(0, 8192), $urandom_range(0, 4096),
                 $urandom_range(0, 8192), $urandom_range(0, 8192), $urandom_range(0, 4096),
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        run_random(40, 1'b1);
        settle();
        write_reg(REG_INTEG_LIMIT, $urandom_range(0, 1 << 17));
        run_random(60, 1'b0);
        settle();

        // more random settings
        load_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 rand_limit(), rand_limit());
        run_random(70, 1'b0);
        settle();

        // back to the defaults
        load_all(KP_XY_RST, KD_XY_RST, KI_XY_RST, KP_Z_RST, KD_Z_RST, KI_Z_RST,
                 INTEG_LIMIT_RST, ACC_XY_LIMIT_RST);
        run_random(40, 1'b0);
        settle();

        $display("run: %0d items sent (%0d on axis three), %0d register writes",
                 items_sent, items_dropped, reg_writes);
        $display("run: %0d acceleration commands checked over %0d cycles",
                 checked, cycle_count);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
